// File: rtl/core/sef_pkg.sv
// sef_pkg: shared types and constants for the stamped event queue
// no dependencies; used by the queue cell and the top level
package sef_pkg;

   // operation codes carried in the request
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_PEEK = 2'd1,
      OP_POP  = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   // event kind codes
   localparam logic [1:0] KIND_UNKNOWN = 2'd0;
   localparam logic [1:0] KIND_DRY     = 2'd1;
   localparam logic [1:0] KIND_WET     = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   // highest accepted confidence percent
   localparam logic [7:0] CONF_LIMIT = 8'd100;

   // one stored event
   typedef struct packed {
      logic [31:0] stamp;
      logic [15:0] sequence_num;
      logic [1:0]  kind;
      logic [6:0]  first_conf;
      logic [6:0]  second_conf;
      logic        stamp_known;
      logic        stage_two_known;
   } entry_type;

   // control broadcast to every queue cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

// File: rtl/core/sef_if.sv
// sef_if: request and response channel interfaces with valid/ready handshake
// depends on no other file
interface sef_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] time_seconds;
   logic        time_known;
   logic [1:0]  kind_code;
   logic [7:0]  first_confidence;
   logic [7:0]  second_confidence;

   modport source (
      output valid, opcode, time_seconds, time_known, kind_code,
             first_confidence, second_confidence,
      input  ready
   );
   modport sink (
      input  valid, opcode, time_seconds, time_known, kind_code,
             first_confidence, second_confidence,
      output ready
   );
endinterface

interface sef_rsp_if #(
   parameter int FILL_W = 5
);
   logic              valid;
   logic              ready;
   logic              success;
   logic [31:0]       head_time;
   logic [15:0]       head_sequence;
   logic [1:0]        head_kind;
   logic [6:0]        head_first_conf;
   logic [6:0]        head_second_conf;
   logic              head_time_known;
   logic              head_stage_two_known;
   logic [FILL_W-1:0] fill_level;
   logic [31:0]       drop_total;
   logic [15:0]       upcoming_sequence;

   modport source (
      output valid, success, head_time, head_sequence, head_kind, head_first_conf,
             head_second_conf, head_time_known, head_stage_two_known, fill_level,
             drop_total, upcoming_sequence,
      input  ready
   );
   modport sink (
      input  valid, success, head_time, head_sequence, head_kind, head_first_conf,
             head_second_conf, head_time_known, head_stage_two_known, fill_level,
             drop_total, upcoming_sequence,
      output ready
   );
endinterface

// File: rtl/core/stamped_event_fifo_top.sv
// stamped_event_fifo_top: time-stamped event queue built from a row of shifting cells
// depends on sef_pkg, sef_if (sef_req_if, sef_rsp_if) and sef_cell
//
// Usage:
//   req_chan carries one operation per transfer: push an event, peek at the head,
//   pop the head, or no operation. rsp_chan returns exactly one result per request,
//   in order: success flag, head fields (nonzero only on a successful peek), and
//   the fill level, drop total and next sequence number after the operation.
//   A push with kind 3 or a confidence above 100 is refused without counting a
//   drop; a push into a full queue bumps the wrapping 32-bit drop counter.
//   A result is registered and appears in the cycle after its request transfer.
//   Throughput: one request per cycle unless rsp_chan stalls; every cell
//   updates in the same cycle; pushes fill the first empty cell, pops shift by one.
//   Reset empties the queue and clears the counters; stored payloads are kept.
//   When the receiver stalls, the result register holds its value and req_chan
//   still takes a request in the cycle the pending result is taken.
//   The rsp_chan instance must use FILL_W = $clog2(QUEUE_SLOTS + 1).
module stamped_event_fifo_top #(
   parameter int QUEUE_SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sef_req_if.sink   req_chan,
   sef_rsp_if.source rsp_chan
);
   import sef_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);

   logic                 req_xfer;
   opcode_type           op;
   logic                 push_legal;
   logic                 full;
   logic                 empty;
   logic                 push_ok;
   logic                 drop_hit;
   logic                 peek_ok;
   logic                 pop_ok;
   cell_ctl_type         ctl;
   entry_type            push_entry;
   logic                 cell_valid [QUEUE_SLOTS];
   entry_type            cell_entry [QUEUE_SLOTS];

   logic [FILL_W-1:0]    count_ff;
   logic [FILL_W-1:0]    count_in;
   logic [15:0]          seq_ff;
   logic [15:0]          seq_in;
   logic [31:0]          drop_ff;
   logic [31:0]          drop_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 success_ff;
   logic                 success_in;
   entry_type            head_ff;
   entry_type            head_in;

   // request handshake: take a request whenever the result slot frees up
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign op             = opcode_type'(req_chan.opcode);

   assign full  = cell_valid[QUEUE_SLOTS-1];
   assign empty = !cell_valid[0];

   assign push_legal = (req_chan.kind_code != KIND_INVALID)
                    && (req_chan.first_confidence <= CONF_LIMIT)
                    && (req_chan.second_confidence <= CONF_LIMIT);

   // operation decode
   always_comb begin
      push_ok  = 1'b0;
      drop_hit = 1'b0;
      peek_ok  = 1'b0;
      pop_ok   = 1'b0;
      if (req_xfer) begin
         case (op)
            OP_PUSH: begin
               push_ok  = push_legal && !full;
               drop_hit = push_legal && full;
            end
            OP_PEEK: begin
               peek_ok = !empty;
            end
            OP_POP: begin
               pop_ok = !empty;
            end
            default: begin
               push_ok = 1'b0;
            end
         endcase
      end
   end

   assign ctl.push = push_ok;
   assign ctl.pop  = pop_ok;

   // entry built from the incoming push
   always_comb begin
      push_entry.stamp           = req_chan.time_seconds;
      push_entry.sequence_num    = seq_ff;
      push_entry.kind            = req_chan.kind_code;
      push_entry.first_conf      = req_chan.first_confidence[6:0];
      push_entry.second_conf     = req_chan.second_confidence[6:0];
      push_entry.stamp_known     = req_chan.time_known;
      push_entry.stage_two_known = (req_chan.kind_code == KIND_DRY)
                                || (req_chan.kind_code == KIND_WET);
   end

   // row of cells, head at index 0
   for (genvar i = 0; i < QUEUE_SLOTS; i++) begin : g_cell
      logic      prev_valid;
      logic      next_valid;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = cell_valid[i-1];
      end

      if (i == QUEUE_SLOTS - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_entry = push_entry;
      end else begin : g_link
         assign next_valid = cell_valid[i+1];
         assign next_entry = cell_entry[i+1];
      end

      sef_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_entry (next_entry),
         .push_entry (push_entry),
         .valid      (cell_valid[i]),
         .entry      (cell_entry[i])
      );
   end

   // counters
   always_comb begin
      count_in = count_ff;
      seq_in   = seq_ff;
      drop_in  = drop_ff;
      if (push_ok) begin
         count_in = count_ff + FILL_W'(1);
         seq_in   = seq_ff + 16'd1;
      end else if (pop_ok) begin
         count_in = count_ff - FILL_W'(1);
      end
      if (drop_hit) begin
         drop_in = drop_ff + 32'd1;
      end
   end

   // result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      success_in   = success_ff;
      head_in      = head_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
         success_in   = push_ok || peek_ok || pop_ok;
         head_in      = peek_ok ? cell_entry[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seq_ff       <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      success_ff <= success_in;
      head_ff    <= head_in;
   end

   // result outputs; status fields track the state after the last transfer
   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.success              = success_ff;
   assign rsp_chan.head_time            = head_ff.stamp;
   assign rsp_chan.head_sequence        = head_ff.sequence_num;
   assign rsp_chan.head_kind            = head_ff.kind;
   assign rsp_chan.head_first_conf      = head_ff.first_conf;
   assign rsp_chan.head_second_conf     = head_ff.second_conf;
   assign rsp_chan.head_time_known      = head_ff.stamp_known;
   assign rsp_chan.head_stage_two_known = head_ff.stage_two_known;
   assign rsp_chan.fill_level           = count_ff;
   assign rsp_chan.drop_total           = drop_ff;
   assign rsp_chan.upcoming_sequence    = seq_ff;

endmodule

// File: rtl/core/sef_cell.sv
// sef_cell: one slot of the shifting event queue
// depends on sef_pkg; the head cell sits at index 0 and pops pull from the neighbor behind
module sef_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sef_pkg::cell_ctl_type ctl,
   input  logic                 prev_valid,
   input  logic                 next_valid,
   input  sef_pkg::entry_type   next_entry,
   input  sef_pkg::entry_type   push_entry,
   output logic                 valid,
   output sef_pkg::entry_type   entry
);
   import sef_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;
   logic      take_push;

   // this cell is the first empty one behind the occupied run
   assign take_push = ctl.push && prev_valid && !valid_ff;

   // next state: shift toward head on pop, load at the tail on push
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctl.pop) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (take_push) begin
         valid_in = 1'b1;
         entry_in = push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule
